>>> rtl/l2sh_pkg.sv
// Shared types, constants and functions for the lookup2 string hash block.
// Holds the lane types, the mix step, and the prime table built at elaboration.
// Depends on nothing; imported by lookup2_string_hash_top.
package l2sh_pkg;

    localparam int SEED_W      = 11;
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int BLOCK_BYTES = 12;
    localparam int POS_W       = $clog2(BLOCK_BYTES);
    localparam int MIX_STEPS   = 9;

    localparam int PRIME_DEPTH = 1229;
    localparam int PRIME_LIMIT = 10000;
    localparam int PRIME_W     = $clog2(PRIME_LIMIT);
    localparam int PRIME_IDX_W = $clog2(PRIME_DEPTH);

    localparam logic [WORD_W-1:0]  GOLDEN    = 32'h9e3779b9;
    localparam logic [POS_W-1:0]   LAST_POS  = POS_W'(BLOCK_BYTES - 1);
    localparam logic [SEED_W-1:0]  SEED_MAX  = SEED_W'(PRIME_DEPTH - 1);

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
    } lanes_t;

    typedef logic [BLOCK_BYTES-1:0][BYTE_W-1:0] block_t;

    typedef logic [PRIME_DEPTH-1:0][PRIME_W-1:0] prime_tab_t;

    // Sieve over the numbers below the limit, then collect the primes in order.
    function automatic prime_tab_t build_prime_table();
        prime_tab_t             tab;
        logic [PRIME_LIMIT-1:0] comp;
        int                     n;
        tab  = '0;
        comp = '0;
        n    = 0;
        for (int i = 2; i * i < PRIME_LIMIT; i++)
        begin
            if (!comp[i])
            begin
                for (int j = i * i; j < PRIME_LIMIT; j += i)
                begin
                    comp[j] = 1'b1;
                end
            end
        end
        for (int i = 2; i < PRIME_LIMIT; i++)
        begin
            if (!comp[i] && (n < PRIME_DEPTH))
            begin
                tab[n] = PRIME_W'(i);
                n++;
            end
        end
        return tab;
    endfunction

    localparam prime_tab_t PRIME_ROM = build_prime_table();

    // One line of the lookup2 mix: two subtractions, then an xor with a shifted lane.
    function automatic lanes_t mix_step(lanes_t x, logic [3:0] step);
        lanes_t y;
        y = x;
        case (step)
            4'd0: y.a = (x.a - x.b - x.c) ^ (x.c >> 13);
            4'd1: y.b = (x.b - x.c - x.a) ^ (x.a << 8);
            4'd2: y.c = (x.c - x.a - x.b) ^ (x.b >> 13);
            4'd3: y.a = (x.a - x.b - x.c) ^ (x.c >> 12);
            4'd4: y.b = (x.b - x.c - x.a) ^ (x.a << 16);
            4'd5: y.c = (x.c - x.a - x.b) ^ (x.b >> 5);
            4'd6: y.a = (x.a - x.b - x.c) ^ (x.c >> 3);
            4'd7: y.b = (x.b - x.c - x.a) ^ (x.a << 10);
            4'd8: y.c = (x.c - x.a - x.b) ^ (x.b >> 15);
            default: y = x;
        endcase
        return y;
    endfunction

    function automatic lanes_t lanes_add(lanes_t x, lanes_t y);
        lanes_t z;
        z.a = x.a + y.a;
        z.b = x.b + y.b;
        z.c = x.c + y.c;
        return z;
    endfunction

endpackage

>>> rtl/lookup2_string_hash_top.sv
// Throughput: one input transaction per cycle while in_stall is low; the block mix and the
// final mix each run through a pipeline whose first stage adds to the lanes, then one mix
// line per stage.
// Input is stalled only while a result waits at the output and another has reached the
// last pipeline stage. Reset (rst_n low, asynchronous) empties the pipeline and restarts
// the key state; no clearing pass is needed.
module lookup2_string_hash_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [l2sh_pkg::SEED_W-1:0] seed_index,
    input  logic [l2sh_pkg::BYTE_W-1:0] data_byte,
    input  logic                        has_byte,
    input  logic                        is_first,
    input  logic                        is_last,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [l2sh_pkg::WORD_W-1:0] hash_value
);
    import l2sh_pkg::*;

    typedef struct packed {
        block_t blk;
        logic   blk_fresh;
        lanes_t fin;
        logic   fin_fresh;
        logic   first;
    } iss_t;

    typedef struct packed {
        lanes_t               lanes;
        lanes_t               fin;
        logic                 fin_fresh;
        logic [PRIME_W-1:0]   cinit;
    } stage_t;

    logic                   adv;
    logic                   accept;

    // Front end: the open block and the running key length.
    block_t                 buf_reg, buf_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [WORD_W-1:0]      len_reg, len_next;
    logic                   fresh_reg, fresh_next;

    block_t                 work_buf;
    logic [POS_W-1:0]       work_pos;
    logic [WORD_W-1:0]      work_len;
    logic                   work_fresh;
    logic                   blk_hit;

    iss_t                   iss_reg, iss_next;
    logic                   iss_v_reg, iss_blk_reg, iss_last_reg;
    logic [PRIME_W-1:0]     prime_q_reg;
    logic [SEED_W-1:0]      rom_idx;

    logic [PRIME_W-1:0]     cinit_reg, cinit_next;
    logic [PRIME_W-1:0]     cinit_cur;
    lanes_t                 lanes_reg;
    lanes_t                 blk_base;
    lanes_t                 blk_lanes;

    stage_t                 s_reg  [MIX_STEPS+1];
    stage_t                 s_next [MIX_STEPS+1];
    logic [MIX_STEPS:0]     s_blk_reg, s_last_reg;

    lanes_t                 fin_base;
    lanes_t                 f_reg  [MIX_STEPS+1];
    lanes_t                 f_next [MIX_STEPS+1];
    logic [MIX_STEPS:0]     f_v_reg;

    logic                   out_valid_reg;
    logic [WORD_W-1:0]      hash_reg;

    assign adv      = !(out_valid_reg && out_stall && f_v_reg[MIX_STEPS]);
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    assign rom_idx  = (seed_index > SEED_MAX) ? SEED_MAX : seed_index;

    always_comb
    begin
        work_buf   = is_first ? '0 : buf_reg;
        work_pos   = is_first ? '0 : pos_reg;
        work_len   = is_first ? '0 : len_reg;
        work_fresh = is_first ? 1'b1 : fresh_reg;
        blk_hit    = has_byte && (work_pos == LAST_POS);

        if (has_byte)
        begin
            work_buf[work_pos] = data_byte;
            work_len           = work_len + WORD_W'(1);
        end

        iss_next.blk       = work_buf;
        iss_next.blk_fresh = work_fresh;
        iss_next.first     = is_first;

        buf_next   = work_buf;
        pos_next   = work_pos;
        len_next   = work_len;
        fresh_next = work_fresh;
        if (blk_hit)
        begin
            buf_next   = '0;
            pos_next   = '0;
            fresh_next = 1'b0;
        end
        else if (has_byte)
        begin
            pos_next = work_pos + POS_W'(1);
        end

        iss_next.fin.a     = buf_next[3:0];
        iss_next.fin.b     = buf_next[7:4];
        iss_next.fin.c     = {buf_next[10:8], 8'h00} + len_next;
        iss_next.fin_fresh = fresh_next;

        if (is_last)
        begin
            buf_next   = '0;
            pos_next   = '0;
            len_next   = '0;
            fresh_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg   <= '0;
            pos_reg   <= '0;
            len_reg   <= '0;
            fresh_reg <= 1'b1;
        end
        else if (accept)
        begin
            buf_reg   <= buf_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            fresh_reg <= fresh_next;
        end
    end

    // Issue register; the prime table read is registered alongside it.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            iss_reg     <= iss_next;
            prime_q_reg <= PRIME_ROM[rom_idx[PRIME_IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_v_reg    <= 1'b0;
            iss_blk_reg  <= 1'b0;
            iss_last_reg <= 1'b0;
        end
        else if (adv)
        begin
            iss_v_reg    <= accept;
            iss_blk_reg  <= accept && blk_hit;
            iss_last_reg <= accept && is_last;
        end
    end

    // The prime seeding lane c is tracked per key in issue order.
    always_comb
    begin
        cinit_cur  = iss_reg.first ? prime_q_reg : cinit_reg;
        cinit_next = cinit_reg;
        if (iss_v_reg)
        begin
            cinit_next = iss_last_reg ? '0 : cinit_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cinit_reg <= '0;
        end
        else if (adv)
        begin
            cinit_reg <= cinit_next;
        end
    end

    // Block mix pipeline: stage zero adds the block to the lanes, then one mix line a stage.
    always_comb
    begin
        blk_base      = iss_reg.blk_fresh ? {GOLDEN, GOLDEN, WORD_W'(cinit_cur)} : lanes_reg;
        blk_lanes.a   = iss_reg.blk[3:0];
        blk_lanes.b   = iss_reg.blk[7:4];
        blk_lanes.c   = iss_reg.blk[11:8];

        s_next[0].lanes     = lanes_add(blk_base, blk_lanes);
        s_next[0].fin       = iss_reg.fin;
        s_next[0].fin_fresh = iss_reg.fin_fresh;
        s_next[0].cinit     = cinit_cur;
        for (int k = 1; k <= MIX_STEPS; k++)
        begin
            s_next[k]       = s_reg[k-1];
            s_next[k].lanes = mix_step(s_reg[k-1].lanes, 4'(k - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_reg <= s_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_blk_reg  <= '0;
            s_last_reg <= '0;
        end
        else if (adv)
        begin
            s_blk_reg  <= {s_blk_reg[MIX_STEPS-1:0], iss_blk_reg};
            s_last_reg <= {s_last_reg[MIX_STEPS-1:0], iss_last_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s_blk_reg[MIX_STEPS])
        begin
            lanes_reg <= s_reg[MIX_STEPS].lanes;
        end
    end

    // Final mix pipeline: the tail and the length join the lanes of the last block, or the initial lanes if none.
    always_comb
    begin
        if (s_reg[MIX_STEPS].fin_fresh)
        begin
            fin_base = {GOLDEN, GOLDEN, WORD_W'(s_reg[MIX_STEPS].cinit)};
        end
        else if (s_blk_reg[MIX_STEPS])
        begin
            fin_base = s_reg[MIX_STEPS].lanes;
        end
        else
        begin
            fin_base = lanes_reg;
        end

        f_next[0] = lanes_add(fin_base, s_reg[MIX_STEPS].fin);
        for (int k = 1; k <= MIX_STEPS; k++)
        begin
            f_next[k] = mix_step(f_reg[k-1], 4'(k - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_reg <= f_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= '0;
        end
        else if (adv)
        begin
            f_v_reg <= {f_v_reg[MIX_STEPS-1:0], s_last_reg[MIX_STEPS]};
        end
    end

    // Output register: a waiting result holds up the pipeline only once another reaches the last stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && f_v_reg[MIX_STEPS])
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && f_v_reg[MIX_STEPS])
        begin
            hash_reg <= f_reg[MIX_STEPS].c;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    // Input is held back only when a second result would overrun the output register.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && f_v_reg[MIX_STEPS]))
        else $error("input stalled while the output path had room");

    // Block mixes of one stream are at least twelve transactions apart.
    a_block_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        s_blk_reg[MIX_STEPS] |-> (s_blk_reg[MIX_STEPS-1:0] == '0))
        else $error("two block mixes in flight at once");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("block position beyond the end of a block");

    a_last_enters_final: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s_last_reg[MIX_STEPS]) |=> f_v_reg[0])
        else $error("end of key lost between the two mix pipelines");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && f_v_reg[MIX_STEPS]) |=>
            (out_valid_reg && (hash_reg == $past(f_reg[MIX_STEPS].c))))
        else $error("finished hash not placed in the output register");

endmodule
